[src/cubic_hermite_spline_engine_core_defines.svh]
// Assertion macros for the port-level checker of the spline engine.
`ifndef CUBIC_HERMITE_SPLINE_ENGINE_CORE_DEFINES_SVH
`define CUBIC_HERMITE_SPLINE_ENGINE_CORE_DEFINES_SVH

// Clocked property, switched off while reset is high.
`define CHSE_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define CHSE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/chse_pkg.sv]
// Shared types, codes and saturation helpers for the spline engine.
`timescale 1ns / 1ps
package chse_pkg;

   typedef logic signed [47:0] q_type;
   typedef logic signed [55:0] wide_type;

   localparam q_type    QLIM  = 48'sd70368744177663;
   localparam wide_type WQLIM = 56'sd70368744177663;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_EVAL   = 2'd2;
   localparam logic [1:0] CMD_FINDMIN = 2'd3;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_NOSEG  = 2'd2;
   localparam logic [1:0] STAT_NOMIN  = 2'd3;

   localparam logic [1:0] MU_MUL  = 2'd0;
   localparam logic [1:0] MU_DIV  = 2'd1;
   localparam logic [1:0] MU_SQRT = 2'd2;

   typedef struct packed {
      logic [31:0] pos;
      logic [31:0] val;
      logic [31:0] slope;
   } knot_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] pos;
      logic [31:0] val;
      logic [31:0] slope;
      logic [31:0] qx;
      logic [1:0]  ord;
   } req_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [47:0] a;
      logic [47:0] b;
   } mu_req_type;

   function automatic wide_type wq(input logic signed [47:0] v);
      return {{8{v[47]}}, v};
   endfunction

   function automatic q_type ext32(input logic signed [31:0] v);
      return {{16{v[31]}}, v};
   endfunction

   function automatic wide_type w32(input logic signed [31:0] v);
      return {{24{v[31]}}, v};
   endfunction

   function automatic q_type sat48(input wide_type v);
      if (v > WQLIM) return QLIM;
      if (v < -WQLIM) return -QLIM;
      return v[47:0];
   endfunction

   function automatic logic signed [31:0] sat32(input q_type v);
      if (v > 48'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -48'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Clamp an unsigned magnitude to QLIM and apply the sign.
   function automatic q_type clampq(input logic [79:0] m, input logic neg);
      logic [47:0] mag;
      mag = (m > 80'(QLIM)) ? QLIM : m[47:0];
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

[src/chse_knot_ram.sv]
// Knot table: one write port, one registered read port.
`timescale 1ns / 1ps
module chse_knot_ram import chse_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  knot_type      wr_data,
   input  logic [AW-1:0] rd_addr,
   output knot_type      rd_data
);

   knot_type mem [DEPTH];
   knot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/chse_math_unit.sv]
// Shared serial arithmetic: rounding multiply, rounding divide, integer square root.
`timescale 1ns / 1ps
module chse_math_unit import chse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  mu_req_type req,
   output logic       done,
   output q_type      result
);

   localparam logic MS_IDLE = 1'b0;
   localparam logic MS_RUN  = 1'b1;

   logic        mst_ff, mst_in;
   logic [1:0]  op_ff, op_in;
   logic        neg_ff, neg_in;
   logic [47:0] ua_ff, ua_in;
   logic [47:0] ub_ff, ub_in;
   logic [95:0] acc_ff, acc_in;
   logic [63:0] num_ff, num_in;
   logic [47:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] root_ff, root_in;
   logic [63:0] bit_ff, bit_in;
   logic [6:0]  cnt_ff, cnt_in;
   q_type       res_ff, res_in;
   logic        done_ff, done_in;

   q_type       a_s, b_s;
   logic [47:0] ua, ub;
   logic [63:0] prod;
   logic [95:0] acc_nx, rnd;
   logic [48:0] rem_sh;
   logic        ge;
   logic [63:0] quo_nx, trial, root_nx;

   always_comb begin
      a_s    = $signed(req.a);
      b_s    = $signed(req.b);
      ua     = a_s[47] ? 48'(-a_s) : req.a;
      ub     = b_s[47] ? 48'(-b_s) : req.b;
      prod   = ua_ff * ub_ff[47:32];
      acc_nx = {acc_ff[79:0], 16'b0} + {32'b0, prod};
      rnd    = acc_nx + 96'd32768;
      rem_sh = {rem_ff, num_ff[63]};
      ge     = rem_sh >= {1'b0, ub_ff};
      quo_nx = {quo_ff[62:0], ge};
      trial  = root_ff + bit_ff;
      root_nx = (num_ff >= trial) ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);

      mst_in  = mst_ff;
      op_in   = op_ff;
      neg_in  = neg_ff;
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      acc_in  = acc_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      res_in  = res_ff;
      done_in = 1'b0;

      unique case (mst_ff)
         MS_IDLE: begin
            if (start) begin
               op_in  = req.op;
               neg_in = a_s[47] ^ b_s[47];
               ua_in  = ua;
               ub_in  = ub;
               unique case (req.op)
                  MU_MUL: begin
                     acc_in = '0;
                     cnt_in = 7'd2;
                     mst_in = MS_RUN;
                  end
                  MU_DIV: begin
                     if (ub == '0) begin
                        res_in  = '0;
                        done_in = 1'b1;
                     end else begin
                        num_in = {ua, 16'b0} + {17'b0, ub[47:1]};
                        rem_in = '0;
                        quo_in = '0;
                        cnt_in = 7'd63;
                        mst_in = MS_RUN;
                     end
                  end
                  MU_SQRT: begin
                     num_in  = {ua, 16'b0};
                     root_in = '0;
                     bit_in  = 64'h4000_0000_0000_0000;
                     cnt_in  = 7'd31;
                     mst_in  = MS_RUN;
                  end
                  default: begin
                     res_in  = '0;
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         MS_RUN: begin
            cnt_in = cnt_ff - 7'd1;
            unique case (op_ff)
               MU_MUL: begin
                  // top partial product first, shift the sum up each step
                  acc_in = acc_nx;
                  ub_in  = ub_ff << 16;
                  if (cnt_ff == '0) res_in = clampq(rnd[95:16], neg_ff);
               end
               MU_DIV: begin
                  rem_in = ge ? 48'(rem_sh - {1'b0, ub_ff}) : rem_sh[47:0];
                  num_in = num_ff << 1;
                  quo_in = quo_nx;
                  if (cnt_ff == '0) res_in = clampq({16'b0, quo_nx}, neg_ff);
               end
               default: begin
                  if (num_ff >= trial) num_in = num_ff - trial;
                  root_in = root_nx;
                  bit_in  = bit_ff >> 2;
                  if (cnt_ff == '0) res_in = $signed({16'b0, root_nx[31:0]});
               end
            endcase
            if (cnt_ff == '0) begin
               mst_in  = MS_IDLE;
               done_in = 1'b1;
            end
         end
         default: mst_in = MS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mst_ff  <= MS_IDLE;
         done_ff <= 1'b0;
      end else begin
         mst_ff  <= mst_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      neg_ff  <= neg_in;
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      acc_ff  <= acc_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

[src/chse_sequencer.sv]
// Command sequencer: table access, segment search, coefficients, Horner and minimum scan.
`timescale 1ns / 1ps
module chse_sequencer import chse_pkg::*; #(
   parameter int MAX_KNOTS = 64,
   parameter int AW        = 6,
   parameter int CW        = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_value,
   output logic [1:0]        rsp_status,
   output logic              mu_start,
   output mu_req_type        mu_req,
   input  logic              mu_done,
   input  q_type             mu_result,
   output logic              wr_en,
   output logic [AW-1:0]     wr_addr,
   output knot_type          wr_data,
   output logic [AW-1:0]     rd_addr,
   input  knot_type          rd_data
);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_DONE    = 5'd1;
   localparam logic [4:0] ST_WAIT    = 5'd2;
   localparam logic [4:0] ST_EV_SRCH = 5'd3;
   localparam logic [4:0] ST_EV_RD0  = 5'd4;
   localparam logic [4:0] ST_EV_RD1  = 5'd5;
   localparam logic [4:0] ST_CF_DF   = 5'd6;
   localparam logic [4:0] ST_CF_C2   = 5'd7;
   localparam logic [4:0] ST_CF_C3A  = 5'd8;
   localparam logic [4:0] ST_CF_C3B  = 5'd9;
   localparam logic [4:0] ST_CF_END  = 5'd10;
   localparam logic [4:0] ST_HN_INIT = 5'd11;
   localparam logic [4:0] ST_HN_MUL  = 5'd12;
   localparam logic [4:0] ST_HN_ADD  = 5'd13;
   localparam logic [4:0] ST_EV_END  = 5'd14;
   localparam logic [4:0] ST_FM_X0   = 5'd15;
   localparam logic [4:0] ST_FM_XN   = 5'd16;
   localparam logic [4:0] ST_FM_SEG  = 5'd17;
   localparam logic [4:0] ST_FM_AB   = 5'd18;
   localparam logic [4:0] ST_FM_AC   = 5'd19;
   localparam logic [4:0] ST_FM_DISC = 5'd20;
   localparam logic [4:0] ST_FM_SQ   = 5'd21;
   localparam logic [4:0] ST_FM_T    = 5'd22;
   localparam logic [4:0] ST_FM_R2   = 5'd23;
   localparam logic [4:0] ST_FM_NEXT = 5'd24;
   localparam logic [4:0] ST_FM_FIN  = 5'd25;

   localparam logic RET_CMD  = 1'b0;
   localparam logic RET_TRY  = 1'b1;
   localparam logic CF_EVAL  = 1'b0;
   localparam logic CF_FMIN  = 1'b1;

   logic [4:0]         state_ff, state_in;
   logic [4:0]         ret_ff, ret_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      i_ff, i_in;
   logic [AW-1:0]      p_ff, p_in;
   q_type              ex_ff, ex_in;
   logic [1:0]         ord_ff, ord_in;
   logic               eret_ff, eret_in;
   logic               cret_ff, cret_in;
   logic               tret_ff, tret_in;
   logic signed [31:0] p0_ff, p0_in, v0_ff, v0_in, s0_ff, s0_in;
   logic signed [31:0] p1_ff, p1_in, v1_ff, v1_in, s1_ff, s1_in;
   q_type              df_ff, df_in, c2_ff, c2_in, c3_ff, c3_in;
   q_type              t_ff, t_in, acc_ff, acc_in;
   logic [1:0]         k_ff, k_in;
   logic signed [31:0] xp_ff, xp_in, xmin_ff, xmin_in, xmax_ff, xmax_in;
   q_type              fa_ff, fa_in, fb_ff, fb_in, fs_ff, fs_in, m1_ff, m1_in;
   logic               found_ff, found_in;
   logic signed [31:0] bv_ff, bv_in, bx_ff, bx_in, tv_ff, tv_in;
   logic [31:0]        res_ff, res_in;
   logic [1:0]         rst_ff, rst_in;
   logic               ov_ff, ov_in;
   logic [31:0]        oval_ff, oval_in;
   logic [1:0]         ost_ff, ost_in;

   q_type              h, disc, fa_c, fb_c, tx, two_a;
   wide_type           addend;
   logic signed [31:0] r32;
   logic [4:0]         cont_st;

   always_comb begin
      h      = ext32(p1_ff) - ext32(p0_ff);
      fa_c   = sat48(3 * wq(c3_ff));
      fb_c   = sat48(2 * wq(c2_ff));
      two_a  = sat48(2 * wq(fa_ff));
      disc   = sat48(wq(m1_ff) - wq(sat48(4 * wq(mu_result))));
      tx     = sat48(w32(xp_ff) + wq(mu_result));
      r32    = sat32(acc_ff);
      cont_st = tret_ff ? ST_FM_NEXT : ST_FM_R2;
      if (k_ff == 2'd3) addend = wq(c2_ff);
      else if (k_ff == 2'd2) addend = (ord_ff == 2'd0) ? w32(s0_ff) : 2 * wq(c2_ff);
      else if (ord_ff == 2'd0) addend = w32(v0_ff);
      else if (ord_ff == 2'd1) addend = w32(s0_ff);
      else addend = 2 * wq(c2_ff);
   end

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;     count_in = count_ff;
      i_in = i_ff;          p_in = p_ff;         ex_in = ex_ff;
      ord_in = ord_ff;      eret_in = eret_ff;   cret_in = cret_ff;
      tret_in = tret_ff;
      p0_in = p0_ff;  v0_in = v0_ff;  s0_in = s0_ff;
      p1_in = p1_ff;  v1_in = v1_ff;  s1_in = s1_ff;
      df_in = df_ff;  c2_in = c2_ff;  c3_in = c3_ff;
      t_in = t_ff;    acc_in = acc_ff; k_in = k_ff;
      xp_in = xp_ff;  xmin_in = xmin_ff; xmax_in = xmax_ff;
      fa_in = fa_ff;  fb_in = fb_ff;  fs_in = fs_ff; m1_in = m1_ff;
      found_in = found_ff; bv_in = bv_ff; bx_in = bx_ff; tv_in = tv_ff;
      res_in = res_ff; rst_in = rst_ff;
      ov_in = ov_ff && !rsp_ready;
      oval_in = oval_ff; ost_in = ost_ff;
      mu_start = 1'b0;
      mu_req   = '{op: MU_MUL, a: '0, b: '0};
      wr_en    = 1'b0;
      wr_addr  = AW'(count_ff);
      wr_data  = '{pos: req.pos, val: req.val, slope: req.slope};
      rd_addr  = i_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               rst_in = STAT_OK;
               state_in = ST_DONE;
               unique case (req.cmd)
                  CMD_CLEAR: count_in = '0;
                  CMD_APPEND: begin
                     if ((CW+1)'(count_ff) >= (CW+1)'(MAX_KNOTS)) begin
                        rst_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_EVAL: begin
                     if (count_ff < CW'(2)) begin
                        rst_in = STAT_NOSEG;
                     end else begin
                        ex_in    = ext32(req.qx);
                        ord_in   = req.ord;
                        eret_in  = RET_CMD;
                        cret_in  = CF_EVAL;
                        i_in     = '0;
                        rd_addr  = AW'(1);
                        state_in = ST_EV_SRCH;
                     end
                  end
                  default: begin
                     if (count_ff < CW'(2)) begin
                        rst_in = STAT_NOSEG;
                     end else begin
                        rd_addr  = '0;
                        state_in = ST_FM_X0;
                     end
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (!ov_ff || rsp_ready) begin
               ov_in    = 1'b1;
               oval_in  = res_ff;
               ost_in   = rst_ff;
               state_in = ST_IDLE;
            end
         end
         ST_WAIT: begin
            if (mu_done) state_in = ret_ff;
         end
         ST_EV_SRCH: begin
            // advance while the query lies past the right end of this segment
            if (((CW+1)'(i_ff) + (CW+1)'(2) < (CW+1)'(count_ff))
                && (ex_ff > ext32(rd_data.pos))) begin
               i_in    = i_ff + AW'(1);
               rd_addr = i_ff + AW'(2);
            end else begin
               rd_addr  = i_ff;
               state_in = ST_EV_RD0;
            end
         end
         ST_EV_RD0: begin
            p0_in = rd_data.pos;  v0_in = rd_data.val;  s0_in = rd_data.slope;
            rd_addr  = i_ff + AW'(1);
            state_in = ST_EV_RD1;
         end
         ST_EV_RD1: begin
            p1_in = rd_data.pos;  v1_in = rd_data.val;  s1_in = rd_data.slope;
            state_in = ST_CF_DF;
         end
         ST_CF_DF: begin
            if (h == '0) begin
               if (cret_ff == CF_FMIN) begin
                  state_in = ST_FM_FIN;
               end else if (eret_ff == RET_CMD) begin
                  res_in   = '0;
                  rst_in   = STAT_NOSEG;
                  state_in = ST_DONE;
               end else begin
                  state_in = cont_st;
               end
            end else begin
               mu_start = 1'b1;
               mu_req   = '{op: MU_DIV, a: ext32(v1_ff) - ext32(v0_ff), b: h};
               ret_in   = ST_CF_C2;
               state_in = ST_WAIT;
            end
         end
         ST_CF_C2: begin
            df_in    = mu_result;
            mu_start = 1'b1;
            mu_req   = '{op: MU_DIV,
                         a: sat48(w32(s0_ff) * 2 - wq(mu_result) * 3 + w32(s1_ff)),
                         b: h};
            ret_in   = ST_CF_C3A;
            state_in = ST_WAIT;
         end
         ST_CF_C3A: begin
            c2_in    = -mu_result;
            mu_start = 1'b1;
            mu_req   = '{op: MU_DIV,
                         a: sat48(w32(s0_ff) - wq(df_ff) * 2 + w32(s1_ff)),
                         b: h};
            ret_in   = ST_CF_C3B;
            state_in = ST_WAIT;
         end
         ST_CF_C3B: begin
            mu_start = 1'b1;
            mu_req   = '{op: MU_DIV, a: mu_result, b: h};
            ret_in   = ST_CF_END;
            state_in = ST_WAIT;
         end
         ST_CF_END: begin
            c3_in    = mu_result;
            state_in = (cret_ff == CF_EVAL) ? ST_HN_INIT : ST_FM_AB;
         end
         ST_HN_INIT: begin
            t_in = sat48(wq(ex_ff) - w32(p0_ff));
            unique case (ord_ff)
               2'd0: begin acc_in = c3_ff;                     k_in = 2'd3; end
               2'd1: begin acc_in = sat48(3 * wq(c3_ff));      k_in = 2'd2; end
               2'd2: begin acc_in = sat48(6 * wq(c3_ff));      k_in = 2'd1; end
               default: begin acc_in = sat48(6 * wq(c3_ff));   k_in = 2'd0; end
            endcase
            state_in = (ord_ff == 2'd3) ? ST_EV_END : ST_HN_MUL;
         end
         ST_HN_MUL: begin
            mu_start = 1'b1;
            mu_req   = '{op: MU_MUL, a: t_ff, b: acc_ff};
            ret_in   = ST_HN_ADD;
            state_in = ST_WAIT;
         end
         ST_HN_ADD: begin
            acc_in   = sat48(addend + wq(mu_result));
            k_in     = k_ff - 2'd1;
            state_in = (k_ff == 2'd1) ? ST_EV_END : ST_HN_MUL;
         end
         ST_EV_END: begin
            if (eret_ff == RET_CMD) begin
               res_in   = r32;
               rst_in   = STAT_OK;
               state_in = ST_DONE;
            end else if (ord_ff == 2'd0) begin
               // same segment: rerun Horner for the second derivative
               tv_in    = r32;
               ord_in   = 2'd2;
               state_in = ST_HN_INIT;
            end else begin
               if ((r32 > 32'sd0) && (!found_ff || (tv_ff < bv_ff))) begin
                  found_in = 1'b1;
                  bv_in    = tv_ff;
                  bx_in    = ex_ff[31:0];
               end
               state_in = cont_st;
            end
         end
         ST_FM_X0: begin
            xmin_in  = rd_data.pos;
            rd_addr  = AW'(count_ff - CW'(1));
            state_in = ST_FM_XN;
         end
         ST_FM_XN: begin
            xmax_in  = rd_data.pos;
            p_in     = '0;
            found_in = 1'b0;
            state_in = ST_FM_SEG;
         end
         ST_FM_SEG: begin
            i_in     = p_ff;
            rd_addr  = p_ff;
            cret_in  = CF_FMIN;
            state_in = ST_EV_RD0;
         end
         ST_FM_AB: begin
            fa_in    = fa_c;
            fb_in    = fb_c;
            xp_in    = p0_ff;
            mu_start = 1'b1;
            mu_req   = '{op: MU_MUL, a: fb_c, b: fb_c};
            ret_in   = ST_FM_AC;
            state_in = ST_WAIT;
         end
         ST_FM_AC: begin
            m1_in    = mu_result;
            mu_start = 1'b1;
            mu_req   = '{op: MU_MUL, a: fa_ff, b: ext32(s0_ff)};
            ret_in   = ST_FM_DISC;
            state_in = ST_WAIT;
         end
         ST_FM_DISC: begin
            if (disc < 0) begin
               state_in = ST_FM_NEXT;
            end else if (fa_ff != '0) begin
               mu_start = 1'b1;
               mu_req   = '{op: MU_SQRT, a: disc, b: '0};
               ret_in   = ST_FM_SQ;
               state_in = ST_WAIT;
            end else if (fb_ff != '0) begin
               mu_start = 1'b1;
               mu_req   = '{op: MU_DIV, a: -ext32(s0_ff), b: fb_ff};
               tret_in  = 1'b1;
               ret_in   = ST_FM_T;
               state_in = ST_WAIT;
            end else begin
               state_in = ST_FM_NEXT;
            end
         end
         ST_FM_SQ: begin
            fs_in    = mu_result;
            mu_start = 1'b1;
            mu_req   = '{op: MU_DIV, a: sat48(-wq(mu_result) - wq(fb_ff)), b: two_a};
            tret_in  = 1'b0;
            ret_in   = ST_FM_T;
            state_in = ST_WAIT;
         end
         ST_FM_T: begin
            if ((tx < ext32(xmin_ff)) || (tx > ext32(xmax_ff))) begin
               state_in = cont_st;
            end else begin
               ex_in    = tx;
               ord_in   = 2'd0;
               eret_in  = RET_TRY;
               cret_in  = CF_EVAL;
               i_in     = '0;
               rd_addr  = AW'(1);
               state_in = ST_EV_SRCH;
            end
         end
         ST_FM_R2: begin
            mu_start = 1'b1;
            mu_req   = '{op: MU_DIV, a: sat48(wq(fs_ff) - wq(fb_ff)), b: two_a};
            tret_in  = 1'b1;
            ret_in   = ST_FM_T;
            state_in = ST_WAIT;
         end
         ST_FM_NEXT: begin
            if ((CW+1)'(p_ff) + (CW+1)'(2) < (CW+1)'(count_ff)) begin
               p_in     = p_ff + AW'(1);
               state_in = ST_FM_SEG;
            end else begin
               state_in = ST_FM_FIN;
            end
         end
         ST_FM_FIN: begin
            res_in   = found_ff ? bx_ff : '0;
            rst_in   = found_ff ? STAT_OK : STAT_NOMIN;
            state_in = ST_DONE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ov_ff    <= ov_in;
      end
      ret_ff <= ret_in;    i_ff <= i_in;        p_ff <= p_in;
      ex_ff <= ex_in;      ord_ff <= ord_in;    eret_ff <= eret_in;
      cret_ff <= cret_in;  tret_ff <= tret_in;
      p0_ff <= p0_in;  v0_ff <= v0_in;  s0_ff <= s0_in;
      p1_ff <= p1_in;  v1_ff <= v1_in;  s1_ff <= s1_in;
      df_ff <= df_in;  c2_ff <= c2_in;  c3_ff <= c3_in;
      t_ff <= t_in;    acc_ff <= acc_in; k_ff <= k_in;
      xp_ff <= xp_in;  xmin_ff <= xmin_in; xmax_ff <= xmax_in;
      fa_ff <= fa_in;  fb_ff <= fb_in;  fs_ff <= fs_in;  m1_ff <= m1_in;
      found_ff <= found_in; bv_ff <= bv_in; bx_ff <= bx_in; tv_ff <= tv_in;
      res_ff <= res_in; rst_ff <= rst_in;
      oval_ff <= oval_in; ost_ff <= ost_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = ov_ff;
   assign rsp_value  = oval_ff;
   assign rsp_status = ost_ff;

endmodule

[src/cubic_hermite_spline_engine_core.sv]
// Top level of the cubic Hermite spline engine.
// Evaluate: search to the segment, read its two knots, four coefficient divisions, then
// multiply-add steps (three for the value, two for the slope, one for curvature).
// Find minimum: per segment coefficients, square root, two root divisions (one division
// when the cubic term is zero) and two evaluations per root in range. One transaction in
// flight; the serial divider sets the rate. Reset (synchronous, active high) empties the
// table and drops any pending response.
`timescale 1ns / 1ps
module cubic_hermite_spline_engine_core import chse_pkg::*; #(
   parameter int MAX_KNOTS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // knot_position[31:0], knot_value[63:32], knot_slope[95:64], query_x[127:96],
   // deriv_order[129:128], zero pad[135:130]
   input  logic [135:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_value[31:0]
   output logic [31:0]  rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser
);

   localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
   localparam int CW = $clog2(MAX_KNOTS + 1);

   req_type       req;
   logic          mu_start, mu_done;
   mu_req_type    mu_req;
   q_type         mu_result;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   knot_type      wr_data, rd_data;

   assign req = '{cmd: req_tuser, pos: req_tdata[31:0], val: req_tdata[63:32],
                  slope: req_tdata[95:64], qx: req_tdata[127:96],
                  ord: req_tdata[129:128]};

   chse_sequencer #(.MAX_KNOTS(MAX_KNOTS), .AW(AW), .CW(CW)) u_seq (
      .clock(clock), .reset(reset),
      .req_valid(req_tvalid), .req_ready(req_tready), .req(req),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_value(rsp_tdata), .rsp_status(rsp_tuser),
      .mu_start(mu_start), .mu_req(mu_req), .mu_done(mu_done), .mu_result(mu_result),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   chse_math_unit u_math (
      .clock(clock), .reset(reset), .start(mu_start), .req(mu_req),
      .done(mu_done), .result(mu_result)
   );

   chse_knot_ram #(.DEPTH(MAX_KNOTS), .AW(AW)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

endmodule

[src/chse_checker.sv]
// Port-level checker for the spline engine and its bind.
`timescale 1ns / 1ps
`include "cubic_hermite_spline_engine_core_defines.svh"
module chse_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   `CHSE_ASSERT_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "response dropped while stalled")
   `CHSE_ASSERT_RST(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")
   `CHSE_ASSERT_RST(a_busy, clock, reset, req_tvalid && req_tready |=> !req_tready, "second transaction taken while busy")
   `CHSE_ASSERT_RST(a_rsp_source, clock, reset, $rose(rsp_tvalid) |-> !$past(req_tready), "response without a transaction in work")
   `CHSE_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

bind cubic_hermite_spline_engine_core chse_checker u_chse_checker (.*);

[tb/tb_cubic_hermite_spline_engine_core.sv]
// Self-checking testbench for the cubic Hermite spline engine core.
`timescale 1ns / 1ps
module tb_cubic_hermite_spline_engine_core;
   import chse_pkg::*;

   localparam int      KNOT_DEPTH = 64;
   localparam longint  Q_MAX      = 64'sd70368744177663;
   localparam longint  ONE        = 64'sd65536;
   localparam longint  CYCLE_CAP  = 20000000;
   localparam int      ITEM_GOAL  = 2000;

   typedef struct {
      logic [31:0] value;
      logic [1:0]  status;
   } spline_answer_type;

   // Bit-true spline predictor plus the queue of answers still owed by the block.
   class spline_scoreboard;
      longint            knot_x[KNOT_DEPTH];
      longint            knot_y[KNOT_DEPTH];
      longint            knot_s[KNOT_DEPTH];
      int                knot_total;
      spline_answer_type owed[$];
      int                mismatches;
      int                unexpected;
      int                responses;

      function new();
         knot_total = 0;
         mismatches = 0;
         unexpected = 0;
         responses  = 0;
      endfunction

      function longint clip(longint v);
         if (v > Q_MAX) return Q_MAX;
         if (v < -Q_MAX) return -Q_MAX;
         return v;
      endfunction

      function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint qmul(longint a, longint b);
         logic                neg;
         longint unsigned     ua, ub;
         logic [127:0]        prod;
         logic [127:0]        mag;
         neg  = (a < 0) != (b < 0);
         ua   = (a < 0) ? -a : a;
         ub   = (b < 0) ? -b : b;
         prod = 128'(ua) * 128'(ub) + 128'd32768;
         mag  = prod >> 16;
         if (mag > 128'(Q_MAX)) mag = 128'(Q_MAX);
         return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
      endfunction

      function longint qdiv(longint a, longint b);
         logic            neg;
         longint unsigned ua, ub, q;
         neg = (a < 0) != (b < 0);
         ua  = (a < 0) ? -a : a;
         ub  = (b < 0) ? -b : b;
         if (ub == 0) return 0;
         q = ((ua << 16) + ub / 2) / ub;
         if (q > longint'(Q_MAX)) q = Q_MAX;
         return neg ? -longint'(q) : longint'(q);
      endfunction

      function longint unsigned root64(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'h1 << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      // Cubic coefficients of segment i; zero width gives 0.
      function bit coeffs(int i, output longint c2, output longint c3);
         longint h, df;
         c2 = 0;
         c3 = 0;
         h  = knot_x[i+1] - knot_x[i];
         if (h == 0) return 0;
         df = qdiv(knot_y[i+1] - knot_y[i], h);
         c2 = -qdiv(clip(2 * knot_s[i] - 3 * df + knot_s[i+1]), h);
         c3 = qdiv(qdiv(clip(knot_s[i] - 2 * df + knot_s[i+1]), h), h);
         return 1;
      endfunction

      function logic [1:0] eval_point(longint x, logic [1:0] ord, output longint res);
         int     i;
         longint c2, c3, t, s0, r;
         res = 0;
         i   = 0;
         if (knot_total < 2) return STAT_NOSEG;
         while (i + 2 < knot_total && x > knot_x[i+1]) i++;
         if (!coeffs(i, c2, c3)) return STAT_NOSEG;
         t  = clip(x - knot_x[i]);
         s0 = knot_s[i];
         case (ord)
            2'd0: r = clip(knot_y[i] + qmul(t, clip(s0 + qmul(t, clip(c2 + qmul(t, c3))))));
            2'd1: r = clip(s0 + qmul(t, clip(2 * c2 + qmul(t, clip(3 * c3)))));
            2'd2: r = clip(2 * c2 + qmul(t, clip(6 * c3)));
            default: r = clip(6 * c3);
         endcase
         res = clip32(r);
         return STAT_OK;
      endfunction

      function void weigh_root(longint xp, longint t, inout bit found,
                               inout longint best_v, inout longint best_x);
         longint x, v, w;
         x = clip(xp + t);
         if (x < knot_x[0] || x > knot_x[knot_total-1]) return;
         if (eval_point(x, 2'd0, v) != STAT_OK) return;
         if (eval_point(x, 2'd2, w) != STAT_OK || w <= 0) return;
         if (!found || v < best_v) begin
            found  = 1;
            best_v = v;
            best_x = x;
         end
      endfunction

      function logic [1:0] lowest_point(output longint res);
         bit     found;
         longint best_v, best_x, c2, c3, a, b, c, disc, s;
         found  = 0;
         best_v = 0;
         best_x = 0;
         res    = 0;
         if (knot_total < 2) return STAT_NOSEG;
         for (int p = 0; p + 1 < knot_total; p++) begin
            if (!coeffs(p, c2, c3)) break;
            a    = clip(3 * c3);
            b    = clip(2 * c2);
            c    = knot_s[p];
            disc = clip(qmul(b, b) - clip(4 * qmul(a, c)));
            if (disc < 0) continue;
            if (a != 0) begin
               s = longint'(root64(longint'(disc) << 16));
               weigh_root(knot_x[p], qdiv(clip(-s - b), clip(2 * a)), found, best_v, best_x);
               weigh_root(knot_x[p], qdiv(clip(s - b), clip(2 * a)), found, best_v, best_x);
            end else if (b != 0) begin
               weigh_root(knot_x[p], qdiv(-c, b), found, best_v, best_x);
            end
         end
         if (!found) return STAT_NOMIN;
         res = best_x;
         return STAT_OK;
      endfunction

      // Apply one accepted request and queue the answer it owes.
      function void note_request(logic [1:0] cmd, logic [31:0] x, logic [31:0] y,
                                 logic [31:0] s, logic [31:0] qx, logic [1:0] ord);
         spline_answer_type ans;
         longint            r;
         r          = 0;
         ans.status = STAT_OK;
         case (cmd)
            CMD_CLEAR: knot_total = 0;
            CMD_APPEND: begin
               if (knot_total >= KNOT_DEPTH) begin
                  ans.status = STAT_FULL;
               end else begin
                  knot_x[knot_total] = longint'($signed(x));
                  knot_y[knot_total] = longint'($signed(y));
                  knot_s[knot_total] = longint'($signed(s));
                  knot_total++;
               end
            end
            CMD_EVAL: begin
               ans.status = eval_point(longint'($signed(qx)), ord, r);
               if (ans.status != STAT_OK) r = 0;
            end
            default: ans.status = lowest_point(r);
         endcase
         ans.value = r[31:0];
         owed.push_back(ans);
      endfunction

      function void check_response(logic [31:0] value, logic [1:0] status);
         spline_answer_type exp_ans;
         responses++;
         if (owed.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("ERROR: response %0d with nothing owed: value %h status %0d",
                        responses, value, status);
            return;
         end
         exp_ans = owed.pop_front();
         if (value !== exp_ans.value || status !== exp_ans.status) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
               $display("ERROR: response %0d expected value %h status %0d, got %h status %0d",
                        responses, exp_ans.value, exp_ans.status, value, status);
         end
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic [1:0]   req_tuser = CMD_CLEAR;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [31:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   spline_scoreboard sb = new();
   int     send_idle_pct = 30;
   int     recv_idle_pct = 65;
   int     hold_left = 0;
   longint cycles = 0;
   int     items_sent = 0;
   int     evals_sent = 0;
   int     searches_sent = 0;

   cubic_hermite_spline_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Check each response transaction, then pick the ready for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_item(logic [1:0] cmd, logic [31:0] x, logic [31:0] y,
                            logic [31:0] s, logic [31:0] qx, logic [1:0] ord);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= cmd;
      req_tdata  <= {6'b0, ord, qx, s, y, x};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, x, y, s, qx, ord);
      items_sent++;
      if (cmd == CMD_EVAL) evals_sent++;
      if (cmd == CMD_FINDMIN) searches_sent++;
   endtask

   // Drop valid so the last transaction is not taken again, then wait for every answer.
   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] q32(longint v);
      return v[31:0];
   endfunction

   // Clear, load a non-decreasing table, then query it.
   task automatic run_table(int n, bit allow_search);
      longint x, lo, hi;
      int     queries;
      send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, 2'($urandom));
      x  = longint'($urandom_range(100 * 65536)) - 50 * ONE;
      lo = x;
      for (int k = 0; k < n; k++) begin
         send_item(CMD_APPEND, q32(x),
                   q32(longint'($urandom_range(200 * 65536)) - 100 * ONE),
                   q32(longint'($urandom_range(40 * 65536)) - 20 * ONE), $urandom, 2'($urandom));
         hi = x;
         if ($urandom_range(99) >= 4) x += $urandom_range(1, 4 * 65536);
      end
      queries = $urandom_range(3, 10);
      for (int k = 0; k < queries; k++) begin
         if (allow_search && $urandom_range(99) < 15)
            send_item(CMD_FINDMIN, $urandom, $urandom, $urandom, $urandom, 2'($urandom));
         else if ($urandom_range(99) < 10)
            send_item(CMD_EVAL, $urandom, $urandom, $urandom, $urandom, 2'($urandom));
         else
            send_item(CMD_EVAL, $urandom, $urandom, $urandom,
                      q32(lo - 2 * ONE + longint'($urandom_range(32'(hi - lo + 4 * ONE)))),
                      2'($urandom));
      end
   endtask

   // Unstructured traffic; searches only over short tables to bound the run.
   task automatic run_noise();
      logic [1:0] cmd;
      repeat ($urandom_range(4, 12)) begin
         cmd = 2'($urandom);
         if (cmd == CMD_FINDMIN && sb.knot_total > 12) cmd = CMD_EVAL;
         send_item(cmd, $urandom, $urandom, $urandom, $urandom, 2'($urandom));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty and single-knot tables, every derivative order,
      // extrapolation on both sides, a zero-width segment, extreme fields.
      send_item(CMD_EVAL, 0, 0, 0, 0, 2'd0);
      send_item(CMD_FINDMIN, 0, 0, 0, 0, 2'd0);
      send_item(CMD_APPEND, 0, q32(ONE), q32(-2 * ONE), 0, 2'd0);
      send_item(CMD_FINDMIN, 0, 0, 0, 0, 2'd0);
      send_item(CMD_EVAL, 0, 0, 0, 0, 2'd1);
      send_item(CMD_APPEND, q32(2 * ONE), q32(ONE), q32(2 * ONE), 0, 2'd0);
      for (int o = 0; o < 4; o++) send_item(CMD_EVAL, 0, 0, 0, q32(ONE), 2'(o));
      send_item(CMD_EVAL, 0, 0, 0, q32(-3 * ONE), 2'd0);
      send_item(CMD_EVAL, 0, 0, 0, q32(5 * ONE), 2'd1);
      send_item(CMD_FINDMIN, 0, 0, 0, 0, 2'd0);
      send_item(CMD_APPEND, q32(2 * ONE), q32(3 * ONE), 0, 0, 2'd0);
      send_item(CMD_EVAL, 0, 0, 0, q32(3 * ONE), 2'd0);
      send_item(CMD_FINDMIN, 0, 0, 0, 0, 2'd0);
      send_item(CMD_CLEAR, 0, 0, 0, 0, 2'd0);
      send_item(CMD_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 2'd0);
      send_item(CMD_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 2'd0);
      send_item(CMD_EVAL, 0, 0, 0, 32'h8000_0000, 2'd0);
      send_item(CMD_EVAL, 0, 0, 0, 32'h7FFF_FFFF, 2'd3);
      send_item(CMD_EVAL, 0, 0, 0, 32'h0000_0000, 2'd2);
      send_item(CMD_FINDMIN, 0, 0, 0, 0, 2'd0);

      // Fill the table and append once more.
      run_table(KNOT_DEPTH, 0);
      send_item(CMD_APPEND, $urandom, $urandom, $urandom, 0, 2'd0);

      while (items_sent < ITEM_GOAL) begin
         if (items_sent >= ITEM_GOAL / 3 && send_idle_pct == 30) begin
            drain();
            send_idle_pct = 65;
            recv_idle_pct = 30;
            // Long receiver stall while requests keep coming.
            hold_left = 3000;
         end else if (items_sent >= 2 * ITEM_GOAL / 3 && send_idle_pct == 65) begin
            drain();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case ($urandom_range(19))
            0: run_table(KNOT_DEPTH, 0);
            1, 2: run_noise();
            3: run_table($urandom_range(0, 1), 1);
            default: run_table($urandom_range(2, 8), 1);
         endcase
      end

      drain();
      repeat (400) @(posedge clock);
      $display("Sent %0d requests (%0d evaluations, %0d minimum searches), checked %0d responses",
               items_sent, evals_sent, searches_sent, sb.responses);
      $display("Covered empty, full and zero-width tables, all derivative orders, extrapolation");
      if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+src
src/chse_pkg.sv
src/chse_knot_ram.sv
src/chse_math_unit.sv
src/chse_sequencer.sv
src/cubic_hermite_spline_engine_core.sv
src/chse_checker.sv
tb/tb_cubic_hermite_spline_engine_core.sv
